// File: sv/srw_pkg.sv
// Shared types and constants of the sequence reorder window.
package srw_pkg;

  localparam int unsigned SeqW = 64;
  localparam int unsigned LenW = 12;
  localparam int unsigned TagW = 16;
  localparam int unsigned CntW = 32;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 64;

  // Register index of start_sequence (byte address 8 * index)
  localparam logic REG_START = 1'b0;

  typedef struct packed {
    logic [SeqW-1:0] msg_seq;
    logic [LenW-1:0] msg_len;
    logic [TagW-1:0] payload_tag;
  } msg_t;

  typedef struct packed {
    logic            released;
    logic [SeqW-1:0] out_seq;
    logic [LenW-1:0] out_len;
    logic [TagW-1:0] out_tag;
    logic            accepted;
    logic [CntW-1:0] drop_count;
    logic [CntW-1:0] ooo_count;
    logic [CntW-1:0] recovered_count;
    logic [SeqW-1:0] gap_first;
    logic [SeqW-1:0] gap_last;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic [LenW-1:0] len;
    logic [TagW-1:0] tag;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_DECIDE,
    ST_STORE,
    ST_EMIT1,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_UPDATE,
    ST_EM_HEAD,
    ST_EM_RD,
    ST_EM_OUT
  } state_e;

  typedef struct packed {
    logic latch;
    logic mod_step;
    logic store;
    logic stale;
    logic scan_init;
    logic scan_step;
    logic update;
    logic emit_single;
    logic emit_head;
    logic emit_slot;
  } cmd_t;

  typedef struct packed {
    logic mod_last;
    logic bad_len;
    logic is_eq;
    logic is_old;
    logic match;
    logic full;
    logic cnt_zero;
    logic cnt_one;
  } sts_t;

endpackage

// File: sv/sequence_reorder_window.sv
// Top level of the sequence reorder window.
// Usage: pulse start with a message descriptor on msg_i while busy is low; the
// transaction is taken at that edge and busy stays high until its last result
// has been registered. Results appear on res_o with res_valid_o high for one
// cycle each; the receiver must take them, there is no back-pressure. Every
// transaction gives one or more results, the final one flagged by res_o.last.
// The slot index (sequence mod WINDOW) is found eight bits a cycle. Then a
// rejected descriptor gives its result from the decide state, a stale one
// through an emit state, and a stored one after a store state. An in-order
// descriptor scans the stored chain one slot at a time through the single
// RAM port, with a read and a compare state per slot, then releases itself
// and each of the chained messages in turn, each slot after a RAM read state.
// start_sequence is to be written over the APB-style port while busy is low;
// the block does not enforce this. It loads the next expected number and
// leaves stored slots untouched. Reset clears all slot valid bits, counters and
// the gap, and sets the next expected number to 1; slot contents are not cleared.
module sequence_reorder_window #(
  parameter int unsigned WINDOW       = 16,
  parameter int unsigned MAX_MSG      = 2048,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  srw_pkg::msg_t                 msg_i,
  output logic                          res_valid_o,
  output srw_pkg::res_t                 res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srw_pkg::AddrW-1:0]     paddr,
  input  logic [srw_pkg::DataW-1:0]     pwdata,
  output logic [srw_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  srw_pkg::cmd_t cmd;
  srw_pkg::sts_t sts;
  logic [srw_pkg::DataW-1:0] start_q;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[3] == srw_pkg::REG_START);
  assign prdata = (paddr[3] == srw_pkg::REG_START) ? start_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 64'd1;
    end else if (cfg_we) begin
      start_q <= pwdata;
    end
  end

  srw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  srw_dp #(
    .WINDOW       (WINDOW),
    .MAX_MSG      (MAX_MSG),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .msg_i       (msg_i),
    .cfg_we_i    (cfg_we),
    .cfg_val_i   (pwdata),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// File: sv/srw_ram.sv
// Generic single-port RAM with registered read.
module srw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/srw_ctrl.sv
// Controller state machine of the reorder window.
module srw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  srw_pkg::sts_t  sts_i,
  output srw_pkg::cmd_t  cmd_o
);

  srw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      srw_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = srw_pkg::ST_MOD;
        end
      end
      srw_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = srw_pkg::ST_DECIDE;
      end
      srw_pkg::ST_DECIDE: begin
        priority if (sts_i.bad_len) begin
          cmd_o.emit_single = 1'b1;
          state_d           = srw_pkg::ST_IDLE;
        end else if (sts_i.is_eq) begin
          cmd_o.scan_init = 1'b1;
          state_d         = srw_pkg::ST_SCAN_RD;
        end else if (sts_i.is_old) begin
          cmd_o.stale = 1'b1;
          state_d     = srw_pkg::ST_EMIT1;
        end else begin
          state_d = srw_pkg::ST_STORE;
        end
      end
      srw_pkg::ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = srw_pkg::ST_EMIT1;
      end
      srw_pkg::ST_EMIT1: begin
        cmd_o.emit_single = 1'b1;
        state_d           = srw_pkg::ST_IDLE;
      end
      srw_pkg::ST_SCAN_RD: begin
        state_d = srw_pkg::ST_SCAN_CMP;
      end
      srw_pkg::ST_SCAN_CMP: begin
        if (sts_i.match) begin
          cmd_o.scan_step = 1'b1;
          state_d = sts_i.full ? srw_pkg::ST_UPDATE : srw_pkg::ST_SCAN_RD;
        end else begin
          state_d = srw_pkg::ST_UPDATE;
        end
      end
      srw_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = srw_pkg::ST_EM_HEAD;
      end
      srw_pkg::ST_EM_HEAD: begin
        cmd_o.emit_head = 1'b1;
        state_d = sts_i.cnt_zero ? srw_pkg::ST_IDLE : srw_pkg::ST_EM_RD;
      end
      srw_pkg::ST_EM_RD: begin
        state_d = srw_pkg::ST_EM_OUT;
      end
      srw_pkg::ST_EM_OUT: begin
        cmd_o.emit_slot = 1'b1;
        state_d = sts_i.cnt_one ? srw_pkg::ST_IDLE : srw_pkg::ST_EM_RD;
      end
      default: state_d = srw_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_q != srw_pkg::ST_IDLE);

endmodule

// File: sv/srw_dp.sv
// Datapath of the reorder window: slot store, counters, gap and result register.
module srw_dp #(
  parameter int unsigned WINDOW       = 16,
  parameter int unsigned MAX_MSG      = 2048,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srw_pkg::cmd_t                 cmd_i,
  output srw_pkg::sts_t                 sts_o,
  input  srw_pkg::msg_t                 msg_i,
  input  logic                          cfg_we_i,
  input  logic [srw_pkg::SeqW-1:0]      cfg_val_i,
  output logic                          res_valid_o,
  output srw_pkg::res_t                 res_o
);

  localparam int unsigned RW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = $bits(srw_pkg::slot_t);

  srw_pkg::msg_t msg_q;
  logic [srw_pkg::SeqW-1:0] sh_q, tgt_q, ne_q, gb_q, ge_q;
  logic [2:0]               bcnt_q;
  logic [RW-1:0]            rem_q, ptr_q, base_q, ptr_inc, base_inc, mod_next;
  logic [CW-1:0]            cnt_q;
  logic [WINDOW-1:0]        valid_q;
  logic [srw_pkg::CntW-1:0] drops_q, ooo_q, rec_q;
  logic                     gap_open_q;
  srw_pkg::res_t            res_q;
  logic                     res_valid_q;

  srw_pkg::slot_t rd, wr;
  logic           ram_we, dup, bad, is_old;
  logic [srw_pkg::SeqW-1:0] seq_m1;

  // Remainder by WINDOW, eight bits a cycle, most significant first
  always_comb begin
    logic [RW-1:0] r;
    logic [RW:0]   t;
    r = rem_q;
    for (int i = 0; i < 8; i++) begin
      t = {r, sh_q[srw_pkg::SeqW-1-i]};
      if (t >= (RW+1)'(WINDOW)) t = t - (RW+1)'(WINDOW);
      r = t[RW-1:0];
    end
    mod_next = r;
  end

  assign ptr_inc  = (ptr_q == RW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
  assign base_inc = (base_q == RW'(WINDOW - 1)) ? '0 : base_q + 1'b1;

  assign bad    = (msg_q.msg_len < srw_pkg::LenW'(HEADER_BYTES)) ||
                  (msg_q.msg_len > srw_pkg::LenW'(MAX_MSG));
  assign is_old = (msg_q.msg_seq < ne_q);
  assign dup    = valid_q[ptr_q] && (rd.seq == msg_q.msg_seq);
  assign seq_m1 = msg_q.msg_seq - 64'd1;

  always_comb begin
    sts_o.mod_last = (bcnt_q == 3'd7);
    sts_o.bad_len  = bad;
    sts_o.is_eq    = (msg_q.msg_seq == ne_q);
    sts_o.is_old   = is_old;
    sts_o.match    = valid_q[ptr_q] && (rd.seq == tgt_q);
    sts_o.full     = (cnt_q == CW'(WINDOW - 1));
    sts_o.cnt_zero = (cnt_q == '0);
    sts_o.cnt_one  = (cnt_q == CW'(1));
  end

  assign ram_we  = cmd_i.store && !dup;
  assign wr.seq  = msg_q.msg_seq;
  assign wr.len  = msg_q.msg_len;
  assign wr.tag  = msg_q.payload_tag;

  srw_ram #(.WIDTH(SW), .DEPTH(WINDOW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ptr_q),
    .wdata_i (wr),
    .rdata_o (rd)
  );

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q        <= 64'd1;
      valid_q     <= '0;
      drops_q     <= '0;
      ooo_q       <= '0;
      rec_q       <= '0;
      gap_open_q  <= 1'b0;
      gb_q        <= '0;
      ge_q        <= '0;
      res_valid_q <= 1'b0;
      bcnt_q      <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
    end else begin
      res_valid_q <= cmd_i.emit_single || cmd_i.emit_head || cmd_i.emit_slot;
      if (cfg_we_i) ne_q <= cfg_val_i;
      if (cmd_i.latch) bcnt_q <= '0;
      if (cmd_i.mod_step) begin
        bcnt_q <= bcnt_q + 3'd1;
        if (sts_o.mod_last) ptr_q <= mod_next;
      end
      if (cmd_i.stale) drops_q <= drops_q + 32'd1;
      if (cmd_i.store) begin
        ooo_q <= ooo_q + 32'd1;
        if (!dup) begin
          if (valid_q[ptr_q]) drops_q <= drops_q + 32'd1;
          valid_q[ptr_q] <= 1'b1;
        end
        if (!gap_open_q) begin
          gap_open_q <= 1'b1;
          gb_q       <= ne_q;
          ge_q       <= seq_m1;
        end else if (seq_m1 > ge_q) begin
          ge_q <= seq_m1;
        end
      end
      if (cmd_i.scan_init) begin
        cnt_q <= '0;
        ptr_q <= ptr_inc;
      end
      if (cmd_i.scan_step) begin
        cnt_q <= cnt_q + 1'b1;
        ptr_q <= ptr_inc;
      end
      if (cmd_i.update) begin
        ne_q  <= tgt_q;
        rec_q <= rec_q + srw_pkg::CntW'(cnt_q);
        ptr_q <= base_inc;
        if (gap_open_q && (tgt_q > ge_q)) begin
          gap_open_q <= 1'b0;
          gb_q       <= '0;
          ge_q       <= '0;
        end
      end
      if (cmd_i.emit_slot) begin
        valid_q[ptr_q] <= 1'b0;
        cnt_q          <= cnt_q - 1'b1;
        ptr_q          <= ptr_inc;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      msg_q  <= msg_i;
      sh_q   <= msg_i.msg_seq;
      rem_q  <= '0;
    end
    if (cmd_i.mod_step) begin
      rem_q <= mod_next;
      sh_q  <= sh_q << 8;
      if (sts_o.mod_last) base_q <= mod_next;
    end
    if (cmd_i.scan_init) tgt_q <= msg_q.msg_seq + 64'd1;
    if (cmd_i.scan_step) tgt_q <= tgt_q + 64'd1;
    if (cmd_i.emit_single || cmd_i.emit_head || cmd_i.emit_slot) begin
      res_q.drop_count      <= drops_q;
      res_q.ooo_count       <= ooo_q;
      res_q.recovered_count <= rec_q;
      res_q.gap_first       <= gap_open_q ? gb_q : '0;
      res_q.gap_last        <= gap_open_q ? ge_q : '0;
      priority if (cmd_i.emit_single) begin
        res_q.released <= 1'b0;
        res_q.out_seq  <= '0;
        res_q.out_len  <= '0;
        res_q.out_tag  <= '0;
        res_q.accepted <= !bad && !is_old;
        res_q.last     <= 1'b1;
      end else if (cmd_i.emit_head) begin
        res_q.released <= 1'b1;
        res_q.out_seq  <= msg_q.msg_seq;
        res_q.out_len  <= msg_q.msg_len;
        res_q.out_tag  <= msg_q.payload_tag;
        res_q.accepted <= 1'b1;
        res_q.last     <= sts_o.cnt_zero;
      end else begin
        res_q.released <= 1'b1;
        res_q.out_seq  <= rd.seq;
        res_q.out_len  <= rd.len;
        res_q.out_tag  <= rd.tag;
        res_q.accepted <= 1'b1;
        res_q.last     <= sts_o.cnt_one;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: sv/srw_check.sv
// Port-level checks of the reorder window, bound to the top level.
module srw_check (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      res_valid_o,
  input srw_pkg::res_t             res_o
);

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after a transaction was taken");

  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("still busy on the final result");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !busy |-> res_o.last)
    else $error("non-final result while idle");

  a_norel_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.released |-> res_o.last && (res_o.out_seq == '0))
    else $error("result without release is not a single final result");

  a_rel_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.released |-> res_o.accepted)
    else $error("released message not marked accepted");

endmodule

bind sequence_reorder_window srw_check u_srw_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
